[sv/kcl_pkg.sv]
package kcl_pkg;

	localparam int NUM_KEYS    = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int KEY_W       = 4;
	localparam int CFG_W       = 16;
	localparam int ADDR_W      = $clog2(NUM_KEYS);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_CLICK  = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_DOUBLE     = 2'd2,
		REG_ACTIVE_LOW = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_index;
		logic             raw_level;
		logic             clear_event;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_number;
		logic             pressed;
		logic [1:0]       event_res;
	} rsp_t;

	typedef struct packed {
		logic   stable_pressed;
		count_t debounce_count;
		count_t press_count;
		count_t window_count;
		logic   awaiting_second;
		logic   long_fired;
		event_t latched_event;
	} key_state_t;

	localparam int STATE_W = $bits(key_state_t);

	function automatic count_t sat_inc(input count_t v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
	endfunction

endpackage

[sv/key_click_long_press_detector_unit.sv]
// Debounces up to sixteen keys and reports click, double click and long press per key.
// Each transfer on req is one tick for one key; one result per tick leaves on rsp in the
// same order. Throughput is one tick per clock unless rsp stalls; state is read from the
// per-key state RAM, then updated, written back and put in the result register. Ticks
// back to back for one key are forwarded around the RAM. Write thresholds and active
// levels via cfg only while no tick is in flight (unchecked); cfg_ready is always high.
module key_click_long_press_detector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  kcl_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output kcl_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [kcl_pkg::CFG_W-1:0]     cfg_data
);
	import kcl_pkg::*;

	logic [CFG_W-1:0] debounce_ticks_q, long_press_ticks_q, double_ticks_q, active_low_q;
	logic [NUM_KEYS-1:0] entry_valid_q;

	logic        valid_s1;
	req_t        req_s1;
	logic        fwd_s1;
	logic        entry_valid_s1;
	key_state_t  fwd_data_q;
	logic [STATE_W-1:0] rd_data;

	logic        advance, accept, in_range_s1, wr_en;
	key_state_t  cur, nxt;
	logic        sample;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	assign cfg_ready = 1'b1;
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;
	assign in_range_s1 = ({1'b0, req_s1.key_index} < (KEY_W+1)'(NUM_KEYS));
	assign wr_en     = valid_s1 && advance && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= CFG_W'(20);
			long_press_ticks_q <= CFG_W'(1000);
			double_ticks_q     <= CFG_W'(300);
			active_low_q       <= {CFG_W{1'b1}};
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_DEBOUNCE:   debounce_ticks_q   <= cfg_data;
				REG_LONG_PRESS: long_press_ticks_q <= cfg_data;
				REG_DOUBLE:     double_ticks_q     <= cfg_data;
				REG_ACTIVE_LOW: active_low_q       <= cfg_data;
				default:        ;
			endcase
		end
	end

	kcl_ram #(.WIDTH(STATE_W), .DEPTH(NUM_KEYS)) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (req_s1.key_index[ADDR_W-1:0]),
		.wdata (nxt),
		.re    (accept),
		.raddr (req.key_index[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			entry_valid_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				entry_valid_q[req_s1.key_index[ADDR_W-1:0]] <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1         <= req;
			fwd_s1         <= wr_en && (req.key_index == req_s1.key_index);
			fwd_data_q     <= nxt;
			entry_valid_s1 <= entry_valid_q[req.key_index[ADDR_W-1:0]];
		end
		if (advance && valid_s1) begin
			rsp_q.key_number <= req_s1.key_index;
			rsp_q.pressed    <= in_range_s1 ? nxt.stable_pressed : 1'b0;
			rsp_q.event_res  <= in_range_s1 ? nxt.latched_event : EV_NONE;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_q;
		end else if (entry_valid_s1) begin
			cur = key_state_t'(rd_data);
		end else begin
			cur = '0;
		end
		nxt = cur;
		if (req_s1.clear_event) begin
			nxt.latched_event = EV_NONE;
		end
		sample = active_low_q[req_s1.key_index] ? !req_s1.raw_level : req_s1.raw_level;

		if (sample != nxt.stable_pressed) begin
			nxt.debounce_count = sat_inc(nxt.debounce_count);
			if (nxt.debounce_count >= debounce_ticks_q) begin
				nxt.stable_pressed = sample;
				nxt.debounce_count = '0;
			end
		end else begin
			nxt.debounce_count = '0;
		end

		if (nxt.stable_pressed) begin
			nxt.press_count = sat_inc(nxt.press_count);
			if (long_press_ticks_q != '0 && !nxt.long_fired &&
			    nxt.press_count >= long_press_ticks_q) begin
				nxt.latched_event   = EV_LONG;
				nxt.long_fired      = 1'b1;
				nxt.awaiting_second = 1'b0;
			end
		end else if (nxt.long_fired) begin
			nxt.debounce_count  = '0;
			nxt.press_count     = '0;
			nxt.window_count    = '0;
			nxt.awaiting_second = 1'b0;
			nxt.long_fired      = 1'b0;
		end else if (nxt.press_count != '0) begin
			if (double_ticks_q != '0 && !nxt.awaiting_second) begin
				nxt.awaiting_second = 1'b1;
				nxt.window_count    = '0;
			end else begin
				nxt.latched_event   = (double_ticks_q != '0) ? EV_DOUBLE : EV_CLICK;
				nxt.debounce_count  = '0;
				nxt.window_count    = '0;
				nxt.awaiting_second = 1'b0;
				nxt.long_fired      = 1'b0;
			end
			nxt.press_count = '0;
		end else if (nxt.awaiting_second && double_ticks_q != '0) begin
			nxt.window_count = sat_inc(nxt.window_count);
			if (nxt.window_count >= double_ticks_q) begin
				nxt.latched_event   = EV_CLICK;
				nxt.debounce_count  = '0;
				nxt.press_count     = '0;
				nxt.window_count    = '0;
				nxt.awaiting_second = 1'b0;
				nxt.long_fired      = 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/kcl_ram.sv]
module kcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[dv/key_click_long_press_detector_unit_tb.sv]
`timescale 1ns / 100ps

module key_click_long_press_detector_unit_tb;
	import kcl_pkg::*;

	localparam int QUIET_LIMIT = 500;
	localparam int REQ_W       = $bits(req_t);

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		reg_index_t       idx;
		logic [CFG_W-1:0] val;
		req_t             tick;
		logic             typed;
		rsp_t             want;
	} dir_row_t;

	localparam int N_DIR = 29;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd0,  1'b0, 1'b0}, 1'b1, '{4'd0, 1'b0, EV_NONE}},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd15, 1'b1, 1'b1}, 1'b1, '{4'd15, 1'b0, EV_NONE}},
		'{ROW_CFG,  REG_DEBOUNCE,   16'd0,      '0,                   1'b0, '0},
		'{ROW_CFG,  REG_LONG_PRESS, 16'd2,      '0,                   1'b0, '0},
		'{ROW_CFG,  REG_DOUBLE,     16'd2,      '0,                   1'b0, '0},
		'{ROW_CFG,  REG_ACTIVE_LOW, 16'h00FF,   '0,                   1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd3,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd3,  1'b1, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd3,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd3,  1'b1, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd3,  1'b1, 1'b1}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd3,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd3,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd3,  1'b1, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd9,  1'b1, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd9,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd9,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd9,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd9,  1'b1, 1'b1}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd9,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_CFG,  REG_DOUBLE,     16'd0,      '0,                   1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd9,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd9,  1'b1, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd9,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_CFG,  REG_LONG_PRESS, 16'd0,      '0,                   1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd5,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd5,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd5,  1'b0, 1'b0}, 1'b0, '0},
		'{ROW_TICK, REG_DEBOUNCE,   16'd0,      '{4'd5,  1'b1, 1'b0}, 1'b0, '0}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	key_click_long_press_detector_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// key state mirror
	logic             m_pressed   [NUM_KEYS];
	count_t           m_db_cnt    [NUM_KEYS];
	count_t           m_hold_cnt  [NUM_KEYS];
	count_t           m_win_cnt   [NUM_KEYS];
	logic             m_await     [NUM_KEYS];
	logic             m_long_done [NUM_KEYS];
	event_t           m_event     [NUM_KEYS];
	logic [CFG_W-1:0] debounce_lim;
	logic [CFG_W-1:0] long_lim;
	logic [CFG_W-1:0] double_lim;
	logic [CFG_W-1:0] act_low;

	rsp_t pending_rsp [$];
	rsp_t head_rsp;
	int   n_errors;
	int   n_ticks;
	int   n_writes;
	int   ev_count [4];
	int   quiet;
	int   stall_left;
	bit   idle_en;

	function automatic count_t bump(count_t v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic void latch_event(int k, event_t e);
		m_event[k] = e;
		ev_count[e]++;
	endfunction

	function automatic void drop_gesture(int k);
		m_db_cnt[k]    = '0;
		m_hold_cnt[k]  = '0;
		m_win_cnt[k]   = '0;
		m_await[k]     = 1'b0;
		m_long_done[k] = 1'b0;
	endfunction

	function automatic rsp_t debounce_and_classify(req_t t);
		int   k;
		logic smp;
		rsp_t r;
		k = t.key_index;
		if (t.clear_event)
			m_event[k] = EV_NONE;
		smp = act_low[k] ? ~t.raw_level : t.raw_level;
		if (smp != m_pressed[k]) begin
			m_db_cnt[k] = bump(m_db_cnt[k]);
			if (m_db_cnt[k] >= debounce_lim) begin
				m_pressed[k] = smp;
				m_db_cnt[k]  = '0;
			end
		end else begin
			m_db_cnt[k] = '0;
		end
		if (m_pressed[k]) begin
			m_hold_cnt[k] = bump(m_hold_cnt[k]);
			if (long_lim != 0 && !m_long_done[k] && m_hold_cnt[k] >= long_lim) begin
				latch_event(k, EV_LONG);
				m_long_done[k] = 1'b1;
				m_await[k]     = 1'b0;
			end
		end else if (m_long_done[k]) begin
			drop_gesture(k);
		end else if (m_hold_cnt[k] != 0) begin
			if (double_lim != 0) begin
				if (!m_await[k]) begin
					m_await[k]   = 1'b1;
					m_win_cnt[k] = '0;
				end else begin
					latch_event(k, EV_DOUBLE);
					drop_gesture(k);
				end
			end else begin
				latch_event(k, EV_CLICK);
				drop_gesture(k);
			end
			m_hold_cnt[k] = '0;
		end else if (m_await[k] && double_lim != 0) begin
			m_win_cnt[k] = bump(m_win_cnt[k]);
			if (m_win_cnt[k] >= double_lim) begin
				latch_event(k, EV_CLICK);
				drop_gesture(k);
			end
		end
		r.key_number = t.key_index;
		r.pressed    = m_pressed[k];
		r.event_res  = m_event[k];
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		if (n_errors < 40)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	task automatic send_tick(req_t t, logic typed, rsp_t want);
		rsp_t got;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= t;
		do @(posedge clk); while (req_stall);
		got = debounce_and_classify(t);
		pending_rsp.push_back(typed ? want : got);
		n_ticks++;
	endtask

	task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		// let the pipeline drain
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEBOUNCE:   debounce_lim = val;
			REG_LONG_PRESS: long_lim     = val;
			REG_DOUBLE:     double_lim   = val;
			REG_ACTIVE_LOW: act_low      = val;
			default:        ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold the key in one intended state for n ticks; rough adds glitches, noise and clears
	task automatic tap_key(logic [KEY_W-1:0] k, logic down, int n, bit rough);
		req_t t;
		for (int i = 0; i < n; i++) begin
			if (rough && $urandom_range(0, 7) == 0) begin
				t = req_t'(REQ_W'($urandom));
				send_tick(t, 1'b0, '0);
			end
			t.key_index   = k;
			t.raw_level   = down ^ act_low[k];
			if (rough && $urandom_range(0, 11) == 0)
				t.raw_level = ~t.raw_level;
			t.clear_event = rough && ($urandom_range(0, 5) == 0);
			send_tick(t, 1'b0, '0);
		end
	endtask

	always @(negedge clk) begin
		if (!idle_en) begin
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report("result with nothing pending", rsp.key_number, 0);
			end else begin
				head_rsp = pending_rsp.pop_front();
				if (rsp.key_number !== head_rsp.key_number)
					report("key_number", rsp.key_number, head_rsp.key_number);
				if (rsp.pressed !== head_rsp.pressed)
					report("pressed", rsp.pressed, head_rsp.pressed);
				if (rsp.event_res !== head_rsp.event_res)
					report("event_res", rsp.event_res, head_rsp.event_res);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, QUIET_LIMIT, pending_rsp.size());
			$display("** key_click_long_press_detector_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		int  stop;
		int  hold;
		logic [KEY_W-1:0] k;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		rsp_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		n_errors     = 0;
		n_ticks      = 0;
		n_writes     = 0;
		quiet        = 0;
		stall_left   = 0;
		idle_en      = 1'b1;
		debounce_lim = 16'd20;
		long_lim     = 16'd1000;
		double_lim   = 16'd300;
		act_low      = 16'hFFFF;
		for (int i = 0; i < 4; i++)
			ev_count[i] = 0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			drop_gesture(i);
			m_pressed[i] = 1'b0;
			m_event[i]   = EV_NONE;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_CFG)
				write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].val);
			else
				send_tick(DIR_ROWS[i].tick, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		end

		for (int p = 0; p < 5; p++) begin
			idle_en = (p != 3);
			write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 3)));
			write_reg(REG_LONG_PRESS, (p == 1) ? 16'd0 : 16'($urandom_range(1, 12)));
			write_reg(REG_DOUBLE, (p == 2) ? 16'd0 : 16'($urandom_range(1, 8)));
			write_reg(REG_ACTIVE_LOW, (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 : 16'($urandom));
			stop = n_ticks + 320;
			while (n_ticks < stop) begin
				k    = KEY_W'($urandom_range(0, NUM_KEYS - 1));
				hold = $urandom_range(1, (long_lim == 0) ? 10 : long_lim + 3);
				tap_key(k, 1'b1, debounce_lim + hold, 1'b1);
				tap_key(k, 1'b0, debounce_lim + $urandom_range(0, double_lim + 3), 1'b1);
				if ($urandom_range(0, 1)) begin
					tap_key(k, 1'b1, debounce_lim + $urandom_range(1, 4), 1'b1);
					tap_key(k, 1'b0, debounce_lim + double_lim + 2, 1'b1);
				end
			end
		end

		// widest thresholds on one key
		idle_en = 1'b0;
		write_reg(REG_DEBOUNCE, 16'hFFFF);
		write_reg(REG_LONG_PRESS, 16'hFFFF);
		write_reg(REG_DOUBLE, 16'hFFFF);
		write_reg(REG_ACTIVE_LOW, 16'h0000);
		tap_key(4'd6, 1'b1, 24, 1'b0);
		write_reg(REG_DEBOUNCE, 16'h0000);
		tap_key(4'd6, 1'b0, 1, 1'b0);
		tap_key(4'd6, 1'b1, 1, 1'b0);
		tap_key(4'd6, 1'b0, 24, 1'b0);

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d key ticks across %0d register writes, thresholds from 0 to 65535.",
			n_ticks, n_writes);
		$display("Latched %0d clicks, %0d double clicks and %0d long presses.",
			ev_count[EV_CLICK], ev_count[EV_DOUBLE], ev_count[EV_LONG]);
		if (n_errors == 0)
			$display("** key_click_long_press_detector_unit: PASSED **");
		else
			$display("** key_click_long_press_detector_unit: FAILED **");
		$finish;
	end

endmodule

[sim.f]
sv/kcl_pkg.sv
sv/kcl_ram.sv
sv/key_click_long_press_detector_unit.sv
dv/key_click_long_press_detector_unit_tb.sv
